/* rtl/fcd_pkg.sv */
`default_nettype none

package fcd_pkg;

  localparam int LEG_COUNT_DEF = 4;
  localparam int LEG_NUM_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_ON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_OFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_FRAMES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_FRAMES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_BAND = 3'd5;

  localparam logic [14:0] TORQUE_ON_RST   = 15'd2048;
  localparam logic [14:0] TORQUE_OFF_RST  = 15'd1024;
  localparam logic [15:0] MAX_SPEED_RST   = 16'd500;
  localparam logic [7:0]  ON_FRAMES_RST   = 8'd2;
  localparam logic [7:0]  OFF_FRAMES_RST  = 8'd3;
  localparam logic [13:0] HEIGHT_BAND_RST = 14'd20;

  // Torque differences are scaled by 100; the least span, MIN_SPAN, is 256 in those scaled units.
  localparam logic [6:0]  TQ_SCALE  = 7'd100;
  localparam logic [21:0] MIN_SPAN  = 22'd256;
  // Rounding offset of 2.5 in units of 1/256 after the 4*tq + hq sum.
  localparam logic [9:0]  ROUND_OFS = 10'd640;
  // Division by 5 as a multiply by 52429 / 2^18.
  localparam logic [15:0] RECIP_5   = 16'd52429;
  localparam logic [3:0]  STEP_LAST = 4'd15;
  localparam logic [7:0]  CNT_MAX   = 8'd255;

  typedef enum logic [1:0] {
    PH_AIR    = 2'd0,
    PH_TOUCH  = 2'd1,
    PH_STANCE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_ROOT,
    ST_PHASE,
    ST_DIV,
    ST_CONF,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

/* rtl/fcd_in_if.sv */
`default_nettype none

interface fcd_in_if;
  logic                                valid;
  logic                                ready;
  logic [fcd_pkg::LEG_NUM_W-1:0]       leg_number;
  logic signed [15:0]                  torque_hip;
  logic signed [15:0]                  torque_thigh;
  logic signed [15:0]                  torque_calf;
  logic [15:0]                         foot_speed;
  logic signed [15:0]                  foot_height;
  logic signed [15:0]                  lowest_height;

  modport source (
    output valid, leg_number, torque_hip, torque_thigh, torque_calf,
           foot_speed, foot_height, lowest_height,
    input  ready
  );
  modport sink (
    input  valid, leg_number, torque_hip, torque_thigh, torque_calf,
           foot_speed, foot_height, lowest_height,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/fcd_out_if.sv */
`default_nettype none

interface fcd_out_if;
  logic                          valid;
  logic                          ready;
  logic [fcd_pkg::LEG_NUM_W-1:0] leg_echo;
  logic                          foot_down;
  logic [1:0]                    contact_phase;
  logic [7:0]                    contact_score;

  modport source (
    output valid, leg_echo, foot_down, contact_phase, contact_score,
    input  ready
  );
  modport sink (
    input  valid, leg_echo, foot_down, contact_phase, contact_score,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/fcd_cfg_if.sv */
`default_nettype none

interface fcd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fcd_pkg::CFG_IDX_W-1:0]  index;
  logic [fcd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/foot_contact_detector.sv */
`default_nettype none

// Channel  Direction  Carries
// in_ch    sink       leg number, three joint torques, foot speed, two heights
// out_ch   source     leg echo, contact flag, phase, confidence
// cfg_ch   sink       register index and write data, always ready
//
// An item runs through the 16-step serial squarer, the 16-step square root and
// the phase update, then, when the leg ends in stance, the 16-step divider and
// the confidence step; a leg number at or above LEG_COUNT skips them all.
// Reset is synchronous and active low; it clears the phase machines and the
// frame counters and loads the configuration registers with their defaults.
// A result waits in the output register while the next item is accepted; only
// the last step of a following item stalls behind an untaken result.

module foot_contact_detector #(
  parameter int LEG_COUNT = fcd_pkg::LEG_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fcd_in_if.sink     in_ch,
  fcd_out_if.source  out_ch,
  fcd_cfg_if.sink    cfg_ch
);

  localparam logic [3:0] LEG_LIMIT = 4'(LEG_COUNT);

  fcd_pkg::state_t state_r, state_nxt;

  logic [14:0] on_r, off_r;
  logic [15:0] spd_r;
  logic [7:0]  onf_r, offf_r;
  logic [13:0] band_r;

  fcd_pkg::phase_t leg_phase_r [LEG_COUNT];
  logic [7:0]      td_cnt_r    [LEG_COUNT];
  logic [7:0]      lo_cnt_r    [LEG_COUNT];

  logic [fcd_pkg::LEG_NUM_W-1:0] leg_r;
  logic [15:0] speed_r, e_r;
  logic [31:0] mc_r [3];
  logic [15:0] mp_r [3];
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r;
  logic [17:0] rem_r, rem_nxt;
  logic [15:0] root_r, root_nxt;
  logic [21:0] span_r, tq_rem_r, tq_rem_nxt;
  logic [16:0] tq_r;
  logic [15:0] h_r, h_rem_r, h_rem_nxt;
  logic [16:0] hq_r;
  fcd_pkg::phase_t res_phase_r;
  logic [7:0]  res_conf_r, conf_nxt;

  logic        out_valid_r;
  logic [fcd_pkg::LEG_NUM_W-1:0] out_leg_r;
  logic        out_contact_r;
  fcd_pkg::phase_t out_phase_r;
  logic [7:0]  out_conf_r;

  logic in_ready, in_take, res_take, leg_ok, cnt_last;

  logic [15:0] abs_v [3];
  logic signed [16:0] hdiff;
  logic [15:0] e_in;

  fcd_pkg::phase_t cur_phase, ph_nxt;
  logic [7:0] cur_td, cur_lo, td_nxt, lo_nxt;
  logic td_ev, lo_ev;

  logic [14:0] on_diff;
  logic [21:0] span_raw, span_init, d_clamp, tq_rem_init;
  logic [22:0] d_raw, tq_sh;
  logic        tq0, tq_fit;
  logic [15:0] h_init, h_num, h_rem_init;
  logic        hq0, hq_fit;
  logic [16:0] hq_sh;
  logic [19:0] rem_sh, trial;
  logic [18:0] conf_sum;
  logic [26:0] conf_prod;

  assign leg_ok   = 4'(in_ch.leg_number) < LEG_LIMIT;
  assign in_take  = in_ch.valid && in_ready;
  assign cnt_last = cnt_r == fcd_pkg::STEP_LAST;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcd_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = leg_ok ? fcd_pkg::ST_SQR : fcd_pkg::ST_FIN;
        end
      end
      fcd_pkg::ST_SQR: begin
        if (cnt_last) begin
          state_nxt = fcd_pkg::ST_ROOT;
        end
      end
      fcd_pkg::ST_ROOT: begin
        if (cnt_last) begin
          state_nxt = fcd_pkg::ST_PHASE;
        end
      end
      fcd_pkg::ST_PHASE: begin
        state_nxt = (ph_nxt == fcd_pkg::PH_STANCE) ? fcd_pkg::ST_DIV : fcd_pkg::ST_FIN;
      end
      fcd_pkg::ST_DIV: begin
        if (cnt_last) begin
          state_nxt = fcd_pkg::ST_CONF;
        end
      end
      fcd_pkg::ST_CONF: begin
        state_nxt = fcd_pkg::ST_FIN;
      end
      fcd_pkg::ST_FIN: begin
        if (res_take) begin
          state_nxt = fcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    res_take = 1'b0;
    case (state_r)
      fcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      fcd_pkg::ST_FIN: begin
        res_take = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  assign abs_v[0] = in_ch.torque_hip[15]   ? 16'(~in_ch.torque_hip + 16'sd1)
                                           : 16'(in_ch.torque_hip);
  assign abs_v[1] = in_ch.torque_thigh[15] ? 16'(~in_ch.torque_thigh + 16'sd1)
                                           : 16'(in_ch.torque_thigh);
  assign abs_v[2] = in_ch.torque_calf[15]  ? 16'(~in_ch.torque_calf + 16'sd1)
                                           : 16'(in_ch.torque_calf);
  assign hdiff = {in_ch.foot_height[15], in_ch.foot_height}
               - {in_ch.lowest_height[15], in_ch.lowest_height};
  assign e_in  = (!hdiff[16] && hdiff != 17'sd0) ? hdiff[15:0] : 16'd0;

  // One partial product of each square per cycle.
  assign acc_nxt = acc_r + (mp_r[0][0] ? mc_r[0] : 32'd0)
                         + (mp_r[1][0] ? mc_r[1] : 32'd0)
                         + (mp_r[2][0] ? mc_r[2] : 32'd0);

  // One root bit per cycle from two radicand bits.
  assign rem_sh   = {rem_r, acc_r[31:30]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign rem_nxt  = (rem_sh >= trial) ? 18'(rem_sh - trial) : rem_sh[17:0];
  assign root_nxt = {root_r[14:0], rem_sh >= trial};

  always_comb begin
    cur_phase = fcd_pkg::PH_AIR;
    cur_td    = 8'd0;
    cur_lo    = 8'd0;
    for (int i = 0; i < LEG_COUNT; i++) begin
      if (4'(leg_r) == 4'(i)) begin
        cur_phase = leg_phase_r[i];
        cur_td    = td_cnt_r[i];
        cur_lo    = lo_cnt_r[i];
      end
    end
  end

  assign td_ev = {1'b0, on_r} <= root_r && speed_r <= spd_r;
  assign lo_ev = root_r < {1'b0, off_r};

  always_comb begin
    ph_nxt = cur_phase;
    td_nxt = cur_td;
    lo_nxt = cur_lo;
    case (cur_phase)
      fcd_pkg::PH_TOUCH: begin
        if (td_ev) begin
          td_nxt = (cur_td == fcd_pkg::CNT_MAX) ? cur_td : cur_td + 8'd1;
          if (td_nxt >= onf_r) begin
            ph_nxt = fcd_pkg::PH_STANCE;
          end
        end else begin
          ph_nxt = fcd_pkg::PH_AIR;
          td_nxt = 8'd0;
        end
      end
      fcd_pkg::PH_STANCE: begin
        td_nxt = 8'd0;
        if (lo_ev) begin
          lo_nxt = (cur_lo == fcd_pkg::CNT_MAX) ? cur_lo : cur_lo + 8'd1;
          if (lo_nxt >= offf_r) begin
            ph_nxt = fcd_pkg::PH_AIR;
            lo_nxt = 8'd0;
          end
        end else begin
          lo_nxt = 8'd0;
        end
      end
      default: begin
        ph_nxt = fcd_pkg::PH_AIR;
        lo_nxt = 8'd0;
        if (td_ev) begin
          ph_nxt = fcd_pkg::PH_TOUCH;
          td_nxt = 8'd1;
        end
      end
    endcase
    if (ph_nxt == fcd_pkg::PH_TOUCH && onf_r <= 8'd1) begin
      ph_nxt = fcd_pkg::PH_STANCE;
    end
  end

  assign on_diff     = on_r - off_r;
  assign span_raw    = 22'(on_diff) * 22'(fcd_pkg::TQ_SCALE);
  assign span_init   = (on_r > off_r && span_raw >= fcd_pkg::MIN_SPAN) ? span_raw
                                                                       : fcd_pkg::MIN_SPAN;
  assign d_raw       = (root_r > {1'b0, off_r})
                     ? 23'(root_r - {1'b0, off_r}) * 23'(fcd_pkg::TQ_SCALE) : 23'd0;
  assign d_clamp     = (d_raw > {1'b0, span_init}) ? span_init : d_raw[21:0];
  assign tq0         = d_clamp >= span_init;
  assign tq_rem_init = tq0 ? d_clamp - span_init : d_clamp;

  assign h_init      = (band_r == 14'd0) ? 16'd1 : {band_r, 2'b00};
  assign h_num       = (e_r >= h_init) ? 16'd0 : h_init - e_r;
  assign hq0         = h_num >= h_init;
  assign h_rem_init  = hq0 ? h_num - h_init : h_num;

  assign tq_sh      = {tq_rem_r, 1'b0};
  assign tq_fit     = tq_sh >= {1'b0, span_r};
  assign tq_rem_nxt = tq_fit ? 22'(tq_sh - {1'b0, span_r}) : tq_sh[21:0];
  assign hq_sh      = {h_rem_r, 1'b0};
  assign hq_fit     = hq_sh >= {1'b0, h_r};
  assign h_rem_nxt  = hq_fit ? 16'(hq_sh - {1'b0, h_r}) : hq_sh[15:0];

  assign conf_sum  = 19'({tq_r, 2'b00}) + 19'(hq_r) + 19'(fcd_pkg::ROUND_OFS);
  assign conf_prod = 27'(conf_sum[18:8]) * 27'(fcd_pkg::RECIP_5);
  assign conf_nxt  = conf_prod[26] ? 8'hFF : conf_prod[25:18];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      on_r        <= fcd_pkg::TORQUE_ON_RST;
      off_r       <= fcd_pkg::TORQUE_OFF_RST;
      spd_r       <= fcd_pkg::MAX_SPEED_RST;
      onf_r       <= fcd_pkg::ON_FRAMES_RST;
      offf_r      <= fcd_pkg::OFF_FRAMES_RST;
      band_r      <= fcd_pkg::HEIGHT_BAND_RST;
      for (int i = 0; i < LEG_COUNT; i++) begin
        leg_phase_r[i] <= fcd_pkg::PH_AIR;
        td_cnt_r[i]    <= 8'd0;
        lo_cnt_r[i]    <= 8'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          fcd_pkg::CFG_TORQUE_ON:   on_r   <= cfg_ch.data[14:0];
          fcd_pkg::CFG_TORQUE_OFF:  off_r  <= cfg_ch.data[14:0];
          fcd_pkg::CFG_MAX_SPEED:   spd_r  <= cfg_ch.data;
          fcd_pkg::CFG_ON_FRAMES:   onf_r  <= cfg_ch.data[7:0];
          fcd_pkg::CFG_OFF_FRAMES:  offf_r <= cfg_ch.data[7:0];
          fcd_pkg::CFG_HEIGHT_BAND: band_r <= cfg_ch.data[13:0];
          default: begin
          end
        endcase
      end
      if (state_r == fcd_pkg::ST_PHASE) begin
        for (int i = 0; i < LEG_COUNT; i++) begin
          if (4'(leg_r) == 4'(i)) begin
            leg_phase_r[i] <= ph_nxt;
            td_cnt_r[i]    <= td_nxt;
            lo_cnt_r[i]    <= lo_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      fcd_pkg::ST_IDLE: begin
        leg_r       <= in_ch.leg_number;
        speed_r     <= in_ch.foot_speed;
        e_r         <= e_in;
        acc_r       <= 32'd0;
        cnt_r       <= 4'd0;
        rem_r       <= 18'd0;
        root_r      <= 16'd0;
        res_phase_r <= fcd_pkg::PH_AIR;
        res_conf_r  <= 8'd0;
        for (int k = 0; k < 3; k++) begin
          mc_r[k] <= 32'(abs_v[k]);
          mp_r[k] <= abs_v[k];
        end
      end
      fcd_pkg::ST_SQR: begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + 4'd1;
        for (int k = 0; k < 3; k++) begin
          mc_r[k] <= {mc_r[k][30:0], 1'b0};
          mp_r[k] <= {1'b0, mp_r[k][15:1]};
        end
      end
      fcd_pkg::ST_ROOT: begin
        acc_r  <= {acc_r[29:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r + 4'd1;
      end
      fcd_pkg::ST_PHASE: begin
        res_phase_r <= ph_nxt;
        span_r      <= span_init;
        tq_rem_r    <= tq_rem_init;
        tq_r        <= {16'd0, tq0};
        h_r         <= h_init;
        h_rem_r     <= h_rem_init;
        hq_r        <= {16'd0, hq0};
      end
      fcd_pkg::ST_DIV: begin
        tq_rem_r <= tq_rem_nxt;
        tq_r     <= {tq_r[15:0], tq_fit};
        h_rem_r  <= h_rem_nxt;
        hq_r     <= {hq_r[15:0], hq_fit};
        cnt_r    <= cnt_r + 4'd1;
      end
      fcd_pkg::ST_CONF: begin
        res_conf_r <= conf_nxt;
      end
      default: begin
      end
    endcase
    if (res_take) begin
      out_leg_r     <= leg_r;
      out_contact_r <= res_phase_r == fcd_pkg::PH_STANCE;
      out_phase_r   <= res_phase_r;
      out_conf_r    <= res_conf_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.leg_echo      = out_leg_r;
  assign out_ch.foot_down     = out_contact_r;
  assign out_ch.contact_phase = out_phase_r;
  assign out_ch.contact_score = out_conf_r;

  a_conf_zero_off_stance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_contact_r |-> out_conf_r == 8'd0)
    else $error("confidence nonzero outside stance");

  a_contact_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_contact_r == (out_phase_r == fcd_pkg::PH_STANCE))
    else $error("contact flag disagrees with phase");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fcd_pkg::ST_DIV |-> tq_rem_r < span_r && h_rem_r < h_r)
    else $error("divider remainder out of range");

  a_bad_leg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    res_take && !(4'(leg_r) < LEG_LIMIT) |=> out_phase_r == fcd_pkg::PH_AIR
      && out_conf_r == 8'd0)
    else $error("out-of-range leg produced a contact result");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import fcd_pkg::*;

  localparam int LEGS = LEG_COUNT_DEF;

  typedef struct packed {
    logic [1:0]         leg;
    logic signed [15:0] hip;
    logic signed [15:0] thigh;
    logic signed [15:0] calf;
    logic [15:0]        speed;
    logic signed [15:0] fh;
    logic signed [15:0] lh;
  } frame_t;

  typedef struct packed {
    logic [1:0] leg;
    logic       contact;
    phase_t     phase;
    logic [7:0] conf;
  } verdict_t;

  typedef struct {
    frame_t   f;
    bit       typed;
    verdict_t v;
  } row_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum {FR_PRESS, FR_HOLD, FR_LIFT, FR_NOISE} frame_kind_t;

  typedef struct {
    logic [14:0] on_l;
    logic [14:0] off_l;
    logic [15:0] spd;
    logic [7:0]  onf;
    logic [7:0]  offf;
    logic [13:0] band;
    int          items;
    idle_mode_t  mode;
    bit          one_leg;
  } plan_t;

  logic clk;
  logic rst_n;

  fcd_in_if  in_if ();
  fcd_out_if out_if ();
  fcd_cfg_if cfg_if ();

  foot_contact_detector i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  logic [14:0] on_lvl, off_lvl;
  logic [15:0] speed_max;
  logic [7:0]  on_need, off_need;
  logic [13:0] band_mm;
  phase_t      leg_ph [LEGS];
  logic [7:0]  td_cnt [LEGS];
  logic [7:0]  lo_cnt [LEGS];

  bit leg_pressing [4];
  int leg_left [4];
  int leg_done [4];

  verdict_t pending_verdicts[$];
  row_t     reset_rows[$];
  row_t     equal_rows[$];
  plan_t    plans[$];
  int       mismatch_count = 0;
  int       send_gap_pct = 0;
  int       recv_stall_pct = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void flag(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int i = 17; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic void reset_model();
    on_lvl = TORQUE_ON_RST;
    off_lvl = TORQUE_OFF_RST;
    speed_max = MAX_SPEED_RST;
    on_need = ON_FRAMES_RST;
    off_need = OFF_FRAMES_RST;
    band_mm = HEIGHT_BAND_RST;
    for (int i = 0; i < LEGS; i++) begin
      leg_ph[i] = PH_AIR;
      td_cnt[i] = 8'd0;
      lo_cnt[i] = 8'd0;
    end
  endfunction

  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_TORQUE_ON:   on_lvl = d[14:0];
      CFG_TORQUE_OFF:  off_lvl = d[14:0];
      CFG_MAX_SPEED:   speed_max = d;
      CFG_ON_FRAMES:   on_need = d[7:0];
      CFG_OFF_FRAMES:  off_need = d[7:0];
      CFG_HEIGHT_BAND: band_mm = d[13:0];
      default: ;
    endcase
  endfunction

  function automatic verdict_t predict_contact(frame_t f);
    verdict_t v;
    longint sum;
    longint unsigned mag, span, d, tq, hq, h, e, conf;
    int ex, k;
    bit td_ev, lo_ev;
    v = '{leg: f.leg, contact: 1'b0, phase: PH_AIR, conf: 8'd0};
    if (f.leg >= LEGS) return v;
    k = f.leg;
    sum = longint'(f.hip) * f.hip + longint'(f.thigh) * f.thigh + longint'(f.calf) * f.calf;
    mag = root_floor(sum);
    td_ev = (mag >= on_lvl) && (f.speed <= speed_max);
    lo_ev = mag < off_lvl;
    case (leg_ph[k])
      PH_TOUCH: begin
        if (td_ev) begin
          td_cnt[k] = (td_cnt[k] == CNT_MAX) ? CNT_MAX : td_cnt[k] + 8'd1;
          if (td_cnt[k] >= on_need) leg_ph[k] = PH_STANCE;
        end else begin
          leg_ph[k] = PH_AIR;
          td_cnt[k] = 8'd0;
        end
      end
      PH_STANCE: begin
        td_cnt[k] = 8'd0;
        if (lo_ev) begin
          lo_cnt[k] = (lo_cnt[k] == CNT_MAX) ? CNT_MAX : lo_cnt[k] + 8'd1;
          if (lo_cnt[k] >= off_need) begin
            leg_ph[k] = PH_AIR;
            lo_cnt[k] = 8'd0;
          end
        end else begin
          lo_cnt[k] = 8'd0;
        end
      end
      default: begin
        leg_ph[k] = PH_AIR;
        lo_cnt[k] = 8'd0;
        if (td_ev) begin
          leg_ph[k] = PH_TOUCH;
          td_cnt[k] = 8'd1;
        end
      end
    endcase
    if (leg_ph[k] == PH_TOUCH && on_need <= 8'd1) leg_ph[k] = PH_STANCE;
    v.phase = leg_ph[k];
    if (leg_ph[k] == PH_STANCE) begin
      span = (on_lvl > off_lvl) ? (longint'(on_lvl) - off_lvl) * 100 : 0;
      if (span < 256) span = 256;
      d = (mag > off_lvl) ? (mag - off_lvl) * 100 : 0;
      if (d > span) d = span;
      tq = d * 65536 / span;
      ex = int'(f.fh) - int'(f.lh);
      e = (ex > 0) ? ex : 0;
      h = longint'(band_mm) * 4;
      if (h < 1) h = 1;
      hq = (e >= h) ? 0 : (h - e) * 65536 / h;
      conf = ((4 * tq + hq) * 256 + 163840) / 327680;
      if (conf > 255) conf = 255;
      v.contact = 1'b1;
      v.conf = conf[7:0];
    end
    return v;
  endfunction

  function automatic row_t frame_row(logic [1:0] leg, int hip, int thigh, int calf, int speed,
                                     int fh, int lh, bit typed = 0, logic contact = 0,
                                     phase_t ph = PH_AIR, logic [7:0] conf = 0);
    row_t r;
    r.f = '{leg: leg, hip: 16'(hip), thigh: 16'(thigh), calf: 16'(calf),
            speed: 16'(speed), fh: 16'(fh), lh: 16'(lh)};
    r.typed = typed;
    r.v = '{leg: leg, contact: contact, phase: ph, conf: conf};
    return r;
  endfunction

  function automatic frame_t make_frame(frame_kind_t kind, logic [1:0] leg);
    frame_t f;
    int mag, ofs, main_j;
    logic signed [15:0] joint [3];
    f.leg = leg;
    if (kind == FR_NOISE) begin
      f.hip = 16'($urandom);
      f.thigh = 16'($urandom);
      f.calf = 16'($urandom);
      f.speed = 16'($urandom);
      f.fh = 16'($urandom);
      f.lh = 16'($urandom);
      return f;
    end
    for (int j = 0; j < 3; j++) begin
      joint[j] = 16'sd0;
      if (kind == FR_PRESS) joint[j] = 16'(int'($urandom_range(0, 64)) * ($urandom_range(1) ? -1 : 1));
    end
    case (kind)
      FR_PRESS: mag = on_lvl + $urandom_range(0, 300);
      FR_HOLD:  mag = off_lvl + ((on_lvl > off_lvl) ? $urandom_range(0, on_lvl - off_lvl - 1) : 0);
      default:  mag = (off_lvl == 0) ? 0 : $urandom_range(0, off_lvl - 1);
    endcase
    if (mag > 32767) mag = 32767;
    main_j = $urandom_range(2);
    joint[main_j] = 16'($urandom_range(1) ? -mag : mag);
    f.hip = joint[0];
    f.thigh = joint[1];
    f.calf = joint[2];
    f.speed = (kind == FR_PRESS) ? 16'($urandom_range(0, speed_max)) : 16'($urandom);
    f.lh = 16'($urandom);
    if ($urandom_range(9) < 7) begin
      ofs = int'($urandom_range(0, 4 * band_mm + 40)) - 20;
      f.fh = f.lh + 16'(ofs);
    end else begin
      f.fh = 16'($urandom);
    end
    return f;
  endfunction

  function automatic frame_t next_frame(bit one_leg);
    logic [1:0] leg;
    frame_kind_t kind;
    leg = one_leg ? 2'd0 : 2'($urandom_range(3));
    if (!one_leg && $urandom_range(99) < 12) return make_frame(FR_NOISE, leg);
    if (leg_left[leg] == 0) begin
      leg_pressing[leg] = !leg_pressing[leg];
      leg_done[leg] = 0;
      leg_left[leg] = leg_pressing[leg] ? on_need + $urandom_range(1, 6)
                                        : off_need + $urandom_range(1, 2);
    end
    if (leg_pressing[leg])
      kind = (leg_done[leg] >= on_need && $urandom_range(1)) ? FR_HOLD : FR_PRESS;
    else
      kind = FR_LIFT;
    leg_left[leg]--;
    leg_done[leg]++;
    return make_frame(kind, leg);
  endfunction

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin send_gap_pct = 67; recv_stall_pct = 0; end
      IDLE_RECV: begin send_gap_pct = 0; recv_stall_pct = 67; end
      IDLE_BOTH: begin send_gap_pct = 18; recv_stall_pct = 18; end
      default:   begin send_gap_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  task automatic send_frame(frame_t f, bit typed, verdict_t typed_v);
    verdict_t v;
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.leg_number <= f.leg;
    in_if.torque_hip <= f.hip;
    in_if.torque_thigh <= f.thigh;
    in_if.torque_calf <= f.calf;
    in_if.foot_speed <= f.speed;
    in_if.foot_height <= f.fh;
    in_if.lowest_height <= f.lh;
    do @(posedge clk); while (!in_if.ready);
    v = predict_contact(f);
    pending_verdicts.push_back(typed ? typed_v : v);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    do @(posedge clk); while (!cfg_if.ready);
    store_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [14:0] on_l, logic [14:0] off_l, logic [15:0] spd,
                               logic [7:0] onf, logic [7:0] offf, logic [13:0] band);
    wait_drained();
    repeat (60) @(negedge clk);
    write_reg(CFG_TORQUE_ON, {1'($urandom), on_l});
    write_reg(CFG_TORQUE_OFF, {1'($urandom), off_l});
    write_reg(CFG_MAX_SPEED, spd);
    write_reg(CFG_ON_FRAMES, {8'($urandom), onf});
    write_reg(CFG_OFF_FRAMES, {8'($urandom), offf});
    write_reg(CFG_HEIGHT_BAND, {2'($urandom), band});
    cfg_if.valid <= 1'b0;
    for (int i = 0; i < 4; i++) begin
      leg_pressing[i] = 1'b0;
      leg_left[i] = 0;
    end
  endtask

  always @(negedge clk) out_if.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : result_check
    verdict_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{leg: out_if.leg_echo, contact: out_if.foot_down,
              phase: phase_t'(out_if.contact_phase), conf: out_if.contact_score};
      if (pending_verdicts.size() == 0) begin
        flag($sformatf("result for leg %0d with no transfer pending", got.leg));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.leg !== want.leg)
          flag($sformatf("leg_echo: expected %0d, got %0d", want.leg, got.leg));
        if (got.contact !== want.contact)
          flag($sformatf("leg %0d foot_down: expected %0d, got %0d",
                         want.leg, want.contact, got.contact));
        if (got.phase !== want.phase)
          flag($sformatf("leg %0d contact_phase: expected %0d, got %0d",
                         want.leg, want.phase, got.phase));
        if (got.conf !== want.conf)
          flag($sformatf("leg %0d contact_score: expected %0d, got %0d",
                         want.leg, want.conf, got.conf));
      end
    end
  end

  initial begin
    #20ms;
    $display("** foot_contact_detector: FAILED **");
    $finish;
  end

  initial begin : stimulus
    plan_t p;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.leg_number = '0;
    in_if.torque_hip = '0;
    in_if.torque_thigh = '0;
    in_if.torque_calf = '0;
    in_if.foot_speed = '0;
    in_if.foot_height = '0;
    in_if.lowest_height = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_TORQUE_ON;
    cfg_if.data = '0;
    reset_model();

    reset_rows.push_back(frame_row(0, 0, 0, 0, 0, 0, 0, 1, 0, PH_AIR, 0));
    reset_rows.push_back(frame_row(0, 32767, 32767, 32767, 0, 0, 0, 1, 0, PH_TOUCH, 0));
    reset_rows.push_back(frame_row(0, 32767, 32767, 32767, 500, 0, 0, 1, 1, PH_STANCE, 255));
    reset_rows.push_back(frame_row(0, -32768, -32768, -32768, 65535, 32767, -32768,
                                   1, 1, PH_STANCE, 205));
    reset_rows.push_back(frame_row(0, 0, 0, 0, 0, -32768, 32767, 1, 1, PH_STANCE, 51));
    reset_rows.push_back(frame_row(0, 0, 0, 0, 0, 0, 0, 1, 1, PH_STANCE, 51));
    reset_rows.push_back(frame_row(0, 0, 0, 0, 0, 0, 0, 1, 0, PH_AIR, 0));
    reset_rows.push_back(frame_row(1, 2048, 0, 0, 500, 0, 0));
    reset_rows.push_back(frame_row(1, 2047, 0, 0, 0, 0, 0));
    reset_rows.push_back(frame_row(2, 0, 2048, 0, 501, 0, 0));
    reset_rows.push_back(frame_row(3, 0, -2048, 0, 500, 0, 0));
    reset_rows.push_back(frame_row(3, 0, 0, 2048, 0, 40, 0));
    reset_rows.push_back(frame_row(3, 1023, 0, 0, 0, 79, 0));
    reset_rows.push_back(frame_row(3, 1024, 0, 0, 0, 80, 0));
    reset_rows.push_back(frame_row(3, 0, 0, 0, 0, -5, 0));
    reset_rows.push_back(frame_row(3, 0, 0, 0, 0, 0, 0));
    reset_rows.push_back(frame_row(3, 1536, 0, 0, 0, 20, 0));
    repeat (3) reset_rows.push_back(frame_row(3, 0, 0, 0, 0, 0, 0));

    equal_rows.push_back(frame_row(2, 1500, 0, 0, 65535, 0, 0));
    equal_rows.push_back(frame_row(2, 1601, 0, 0, 0, 1, 0));
    equal_rows.push_back(frame_row(2, 1499, 0, 0, 0, 0, 0, 1, 0, PH_AIR, 0));
    equal_rows.push_back(frame_row(1, 0, 0, 0, 0, 0, 0, 1, 0, PH_AIR, 0));
    equal_rows.push_back(frame_row(0, 32767, -32768, 0, 0, 0, 0));

    plans.push_back('{15'd2048, 15'd1024, 16'd500, 8'd2, 8'd3, 14'd20, 60, IDLE_NONE, 0});
    plans.push_back('{15'd32767, 15'd0, 16'd65535, 8'd1, 8'd1, 14'd16383, 50, IDLE_SEND, 0});
    plans.push_back('{15'd0, 15'd32767, 16'd0, 8'd0, 8'd0, 14'd0, 50, IDLE_RECV, 0});
    plans.push_back('{15'd4000, 15'd3990, 16'd1200, 8'd5, 8'd4, 14'd100, 60, IDLE_BOTH, 0});
    plans.push_back('{15'd3000, 15'd2000, 16'd800, 8'd255, 8'd255, 14'd50, 520, IDLE_NONE, 1});
    plans.push_back('{15'd1000, 15'd3000, 16'd30000, 8'd3, 8'd2, 14'd7, 50, IDLE_BOTH, 0});
    plans.push_back('{15'd2500, 15'd800, 16'd1000, 8'd2, 8'd1, 14'd300, 50, IDLE_RECV, 0});
    plans.push_back('{15'd32767, 15'd32767, 16'd0, 8'd8, 8'd6, 14'd16383, 40, IDLE_SEND, 0});

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idling(IDLE_NONE);
    foreach (reset_rows[i]) send_frame(reset_rows[i].f, reset_rows[i].typed, reset_rows[i].v);
    apply_setting(15'd1500, 15'd1500, 16'd65535, 8'd0, 8'd0, 14'd0);
    set_idling(IDLE_BOTH);
    foreach (equal_rows[i]) send_frame(equal_rows[i].f, equal_rows[i].typed, equal_rows[i].v);

    foreach (plans[n]) begin
      p = plans[n];
      apply_setting(p.on_l, p.off_l, p.spd, p.onf, p.offf, p.band);
      set_idling(p.mode);
      for (int i = 0; i < p.items; i++) begin
        if (n == 0 && i == p.items / 2) wait_drained();
        send_frame(next_frame(p.one_leg), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (60) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** foot_contact_detector: PASSED **");
    end else begin
      $display("** foot_contact_detector: FAILED **");
    end
    $finish;
  end

endmodule
